/* hw/rtl/pst_pkg.sv */
// pst_pkg: opcodes, field widths and the request/response structs of the prefix sum tree
// no dependencies; used by pst_seq and prefix_sum_tree
package pst_pkg;

  localparam int SUM_W = 40;
  localparam int VAL_W = 32;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_PREFIX = 2'd1,
    OP_RANGE  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t               opcode;
    logic [IDX_W-1:0]  index;
    logic [IDX_W-1:0]  other_index;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic              index_error;
  } rsp_t;

  function automatic logic [SUM_W-1:0] sext_value(input logic [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

/* hw/rtl/prefix_sum_tree.sv */
// prefix_sum_tree: top level of the point-update prefix sum tree
// depends on pst_pkg, pst_mem and pst_seq
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   opcode, index, other_index, value
//   out_     output     out_valid/out_stall sum, index_error
//   cfg_     input      cfg_valid/cfg_ready element_count
//
// one transaction at a time; a write updates one node per cycle up the path, and
// prefix and range queries read the tree through the single node store read port
// after reset the store is cleared one node per cycle, all 2*LEAVES-1 nodes, with
// in_stall high; cfg writes are taken at any time
// the result register lets the next transaction start while out_stall holds a result
module prefix_sum_tree #(
  parameter int LEAVES = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input transactions
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic [pst_pkg::IDX_W-1:0] in_index,
  input  logic [pst_pkg::IDX_W-1:0] in_other_index,
  input  logic [pst_pkg::VAL_W-1:0] in_value,
  // result transactions
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pst_pkg::SUM_W-1:0] out_sum,
  output logic                      out_index_error,
  // element count register
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pst_pkg::CNT_W-1:0] cfg_element_count
);

  // heap layout: root at 0, element i in node LEAVES-1+i
  localparam int NODES = 2 * LEAVES - 1;
  localparam int NW    = $clog2(NODES);

  logic [pst_pkg::CNT_W-1:0] count_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [pst_pkg::SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic                      out_err_r, out_err_nxt;

  pst_pkg::req_t             req;
  pst_pkg::rsp_t             rsp;
  logic                      req_ready;
  logic                      rsp_valid;
  logic                      rsp_take;

  logic                      mem_we;
  logic [NW-1:0]             mem_waddr;
  logic [pst_pkg::SUM_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [NW-1:0]             mem_raddr;
  logic [pst_pkg::SUM_W-1:0] mem_rdata;

  // config port never pushes back
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= pst_pkg::CNT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_element_count;
    end
  end

  // input side: the sequencer takes a transaction only when idle
  assign req.opcode      = pst_pkg::op_t'(in_opcode);
  assign req.index       = in_index;
  assign req.other_index = in_other_index;
  assign req.value       = in_value;
  assign in_stall        = !req_ready;

  pst_seq #(
    .LEAVES (LEAVES),
    .NODES  (NODES),
    .NW     (NW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (req_ready),
    .count     (count_r),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_take  (rsp_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // node sums; reads and writes never hit the same node in one cycle
  pst_mem #(
    .DEPTH (NODES),
    .AW    (NW),
    .DW    (pst_pkg::SUM_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register: load when empty or being drained this cycle
  assign rsp_take = rsp_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (rsp_take) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = rsp.sum;
      out_err_nxt   = rsp.index_error;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sum         = out_sum_r;
  assign out_index_error = out_err_r;

endmodule

/* hw/rtl/pst_mem.sv */
// pst_mem: node sum store, one write port and one read port with registered read data
// no dependencies; instantiated by prefix_sum_tree
module pst_mem #(
  parameter int DEPTH = 511,
  parameter int AW    = 9,
  parameter int DW    = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/pst_seq.sv */
// pst_seq: sequencer that clears the node store and runs writes, prefix walks and range walks
// depends on pst_pkg; drives the ports of pst_mem
module pst_seq #(
  parameter int LEAVES = 256,
  parameter int NODES  = 511,
  parameter int NW     = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  input  pst_pkg::req_t             req,
  output logic                      req_ready,
  input  logic [pst_pkg::CNT_W-1:0] count,
  output logic                      rsp_valid,
  output pst_pkg::rsp_t             rsp,
  input  logic                      rsp_take,
  output logic                      mem_we,
  output logic [NW-1:0]             mem_waddr,
  output logic [pst_pkg::SUM_W-1:0] mem_wdata,
  output logic                      mem_re,
  output logic [NW-1:0]             mem_raddr,
  input  logic [pst_pkg::SUM_W-1:0] mem_rdata
);

  localparam int CW = ((NW > pst_pkg::CNT_W) ? NW : pst_pkg::CNT_W) + 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WRD   = 7'b0000100,
    S_WUPD  = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_LAST  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // walk phase: plain prefix, or the three legs of a range query
  typedef enum logic [3:0] {
    PH_PRE  = 4'b0001,
    PH_HI   = 4'b0010,
    PH_LO   = 4'b0100,
    PH_LEAF = 4'b1000
  } phase_t;

  state_t                    state_r, state_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [NW-1:0]             node_r, node_nxt;
  logic [NW-1:0]             clr_r, clr_nxt;
  logic [pst_pkg::SUM_W-1:0] acc_r, acc_nxt;
  logic [pst_pkg::SUM_W-1:0] diff_r, diff_nxt;
  logic [pst_pkg::SUM_W-1:0] nv_r, nv_nxt;
  logic [pst_pkg::IDX_W-1:0] lo_r, lo_nxt;
  logic                      first_r, first_nxt;
  logic                      pend_r, pend_nxt;
  logic                      pend_sub_r, pend_sub_nxt;
  logic                      err_r, err_nxt;

  logic [CW-1:0]             limit;
  logic                      a_bad, b_bad;
  logic [pst_pkg::IDX_W-1:0] lo_idx, hi_idx;
  logic                      on_edge;
  logic [pst_pkg::SUM_W-1:0] acc_upd;

  function automatic logic [NW-1:0] leaf_of(input logic [pst_pkg::IDX_W-1:0] idx);
    return NW'(LEAVES - 1) + NW'(idx);
  endfunction

  assign limit = (CW'(count) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(count);
  assign a_bad = CW'(req.index) >= limit;
  assign b_bad = CW'(req.other_index) >= limit;
  assign lo_idx = (req.index < req.other_index) ? req.index : req.other_index;
  assign hi_idx = (req.index < req.other_index) ? req.other_index : req.index;

  // left edge nodes (2^k - 1) end a prefix walk
  assign on_edge = (node_r & (node_r + NW'(1))) == '0;
  assign acc_upd = pend_sub_r ? (acc_r - mem_rdata) : (acc_r + mem_rdata);

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_DONE);
  assign rsp.sum = acc_r;
  assign rsp.index_error = err_r;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    node_nxt     = node_r;
    clr_nxt      = clr_r;
    acc_nxt      = acc_r;
    diff_nxt     = diff_r;
    nv_nxt       = nv_r;
    lo_nxt       = lo_r;
    first_nxt    = first_r;
    pend_nxt     = pend_r;
    pend_sub_nxt = pend_sub_r;
    err_nxt      = err_r;
    mem_we       = 1'b0;
    mem_waddr    = node_r;
    mem_wdata    = mem_rdata + diff_r;
    mem_re       = 1'b0;
    mem_raddr    = node_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == NW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          acc_nxt      = '0;
          err_nxt      = 1'b0;
          pend_nxt     = 1'b0;
          pend_sub_nxt = 1'b0;
          case (req.opcode)
            pst_pkg::OP_WRITE: begin
              if (a_bad) begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                node_nxt  = leaf_of(req.index);
                nv_nxt    = pst_pkg::sext_value(req.value);
                first_nxt = 1'b1;
                state_nxt = S_WRD;
              end
            end
            pst_pkg::OP_PREFIX: begin
              if (a_bad) begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                node_nxt  = leaf_of(req.index);
                phase_nxt = PH_PRE;
                state_nxt = S_WALK;
              end
            end
            pst_pkg::OP_RANGE: begin
              if (a_bad || b_bad) begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                node_nxt  = leaf_of(hi_idx);
                lo_nxt    = lo_idx;
                phase_nxt = PH_HI;
                state_nxt = S_WALK;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_WRD: begin
        mem_re    = 1'b1;
        state_nxt = S_WUPD;
      end
      S_WUPD: begin
        // write this node, read its parent in the same cycle
        mem_we    = 1'b1;
        first_nxt = 1'b0;
        if (first_r) begin
          mem_wdata = nv_r;
          diff_nxt  = nv_r - mem_rdata;
        end
        if (node_r == '0) begin
          acc_nxt   = nv_r;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = (node_r - NW'(1)) >> 1;
          node_nxt  = (node_r - NW'(1)) >> 1;
        end
      end
      S_WALK: begin
        if (pend_r) begin
          acc_nxt = acc_upd;
        end
        if (phase_r == PH_LEAF) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_sub_nxt = 1'b0;
          state_nxt    = S_LAST;
        end else if (on_edge) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_sub_nxt = (phase_r == PH_LO);
          case (phase_r)
            PH_HI: begin
              phase_nxt = PH_LO;
              node_nxt  = leaf_of(lo_r);
            end
            PH_LO: begin
              phase_nxt = PH_LEAF;
              node_nxt  = leaf_of(lo_r);
            end
            default: begin
              state_nxt = S_LAST;
            end
          endcase
        end else if (node_r[0]) begin
          // left child: take it whole
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_sub_nxt = (phase_r == PH_LO);
          node_nxt     = (node_r - NW'(3)) >> 1;
        end else begin
          pend_nxt = 1'b0;
          node_nxt = (node_r - NW'(2)) >> 1;
        end
      end
      S_LAST: begin
        acc_nxt   = acc_upd;
        pend_nxt  = 1'b0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    node_r     <= node_nxt;
    acc_r      <= acc_nxt;
    diff_r     <= diff_nxt;
    nv_r       <= nv_nxt;
    lo_r       <= lo_nxt;
    first_r    <= first_nxt;
    pend_sub_r <= pend_sub_nxt;
    err_r      <= err_nxt;
  end

endmodule
